[rtl/core/b64_pkg.sv]
package b64_pkg;

  localparam int GROUPS_PER_LINE = 19;
  localparam int LINE_W = $clog2(GROUPS_PER_LINE + 1);
  localparam logic [LINE_W-1:0] LINE_RELOAD = LINE_W'(GROUPS_PER_LINE);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_PAD = 8'h3D;

  typedef enum logic [1:0] {
    REG_PADDING   = 2'd0,
    REG_WRAP      = 2'd1,
    REG_CRLF      = 2'd2,
    REG_ALT_ALPHA = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic padding_enable;
    logic wrap_enable;
    logic crlf_enable;
    logic alt_alpha_enable;
  } cfg_t;

  // one completed group, as handed from the front to the back
  typedef struct packed {
    logic [23:0] bytes;     // b1 in 23:16, b2 in 15:8, b3 in 7:0
    logic [1:0]  count;     // 1..3 data bytes
    logic        line_brk;  // group fills a line
    logic        final_brk; // end of message with wrap on
  } job_t;

  function automatic logic [7:0] sym(input logic [5:0] idx, input logic url);
    logic [7:0] c;
    if (idx < 6'd26)      c = 8'h41 + {2'b00, idx};
    else if (idx < 6'd52) c = 8'h61 + {2'b00, idx - 6'd26};
    else if (idx < 6'd62) c = 8'h30 + {2'b00, idx - 6'd52};
    else if (idx == 6'd62) c = url ? 8'h2D : 8'h2B;
    else                   c = url ? 8'h5F : 8'h2F;
    return c;
  endfunction

endpackage

[rtl/core/b64_if.sv]
interface b64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface b64_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;
  modport source (output valid, out_char, last_char, input ready);
  modport sink   (input valid, out_char, last_char, output ready);
endinterface

interface b64_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/b64_front.sv]
module b64_front (
  input  logic          clk,
  input  logic          rst,
  b64_in_if.sink        bytes,
  input  b64_pkg::cfg_t cfg,
  input  logic          full,
  output logic          push,
  output b64_pkg::job_t push_job
);
  import b64_pkg::*;

  logic [1:0]        phase;
  logic [7:0]        p1;
  logic [7:0]        p2;
  logic [LINE_W-1:0] groups_left;
  logic              accept;
  logic              line_full;

  assign bytes.ready = !full;
  assign accept = bytes.valid && bytes.ready;
  assign line_full = cfg.wrap_enable && (groups_left <= LINE_W'(1));

  always_comb begin
    push_job.line_brk  = line_full;
    push_job.final_brk = bytes.last_byte && cfg.wrap_enable;
    unique case (phase)
      2'd0: begin
        push_job.bytes = {bytes.data_byte, 16'h0000};
        push_job.count = 2'd1;
      end
      2'd1: begin
        push_job.bytes = {p1, bytes.data_byte, 8'h00};
        push_job.count = 2'd2;
      end
      default: begin
        push_job.bytes = {p1, p2, bytes.data_byte};
        push_job.count = 2'd3;
      end
    endcase
    push = accept && (bytes.last_byte || phase == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= 2'd0;
      groups_left <= LINE_RELOAD;
    end else if (accept) begin
      if (push) begin
        phase <= 2'd0;
        if (bytes.last_byte || line_full) groups_left <= LINE_RELOAD;
        else if (cfg.wrap_enable)         groups_left <= groups_left - LINE_W'(1);
      end else begin
        phase <= phase + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && phase == 2'd0) p1 <= bytes.data_byte;
    if (accept && phase == 2'd1) p2 <= bytes.data_byte;
  end

endmodule

[rtl/core/b64_fifo.sv]
module b64_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  b64_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output b64_pkg::job_t head,
  output logic          empty
);
  import b64_pkg::*;

  job_t               entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   fill;

  assign full  = (fill == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty = (fill == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + FIFO_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + FIFO_AW'(1);
      if (push && !pop)      fill <= fill + (FIFO_AW+1)'(1);
      else if (pop && !push) fill <= fill - (FIFO_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

endmodule

[rtl/core/b64_back.sv]
module b64_back (
  input  logic          clk,
  input  logic          rst,
  input  b64_pkg::job_t head,
  input  logic          empty,
  input  b64_pkg::cfg_t cfg,
  output logic          pop,
  b64_out_if.source     chars
);
  import b64_pkg::*;

  logic [2:0] idx;
  logic [2:0] ndata;
  logic [1:0] blen;
  logic [3:0] total;
  logic [2:0] r;
  logic [2:0] r2;
  logic [5:0] sextet;
  logic [7:0] cur_char;
  logic       is_last;
  logic       fire;

  // character list of the head group: data, padding, line break, final break
  always_comb begin
    ndata = cfg.padding_enable ? 3'd4 : {1'b0, head.count} + 3'd1;
    blen  = cfg.crlf_enable ? 2'd2 : 2'd1;
    total = {1'b0, ndata}
          + (head.line_brk  ? {2'b00, blen} : 4'd0)
          + (head.final_brk ? {2'b00, blen} : 4'd0);
    is_last = ({1'b0, idx} == total - 4'd1);

    unique case (idx[1:0])
      2'd0: sextet = head.bytes[23:18];
      2'd1: sextet = head.bytes[17:12];
      2'd2: sextet = head.bytes[11:6];
      default: sextet = head.bytes[5:0];
    endcase

    r  = idx - ndata;
    r2 = r;
    if (head.line_brk && r >= {1'b0, blen}) r2 = r - {1'b0, blen};

    if (idx < ndata) begin
      if (idx[1:0] > head.count) cur_char = CHAR_PAD;
      else                       cur_char = sym(sextet, cfg.alt_alpha_enable);
    end else begin
      cur_char = (cfg.crlf_enable && r2 == 3'd0) ? CHAR_CR : CHAR_LF;
    end
  end

  assign fire = !empty && (!chars.valid || chars.ready);
  assign pop  = fire && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      chars.valid <= 1'b0;
      idx         <= 3'd0;
    end else if (fire) begin
      chars.valid <= 1'b1;
      idx         <= is_last ? 3'd0 : idx + 3'd1;
    end else if (chars.ready) begin
      chars.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      chars.out_char  <= cur_char;
      chars.last_char <= is_last;
    end
  end

endmodule

[rtl/core/base64_stream_encoder.sv]
// Streaming Base64 encoder. Bytes enter on "bytes", one per cycle while the four-group
// queue has room; characters leave on "chars" at one per cycle from a registered output
// while the receiver is ready. A group of three bytes becomes four characters, plus the
// line break characters, so the character sequencer in the back end limits the
// sustained byte rate. last_char marks the final character of each group of up to three
// input bytes. Configuration writes (index 0 padding, 1 wrap, 2 CR LF, 3 URL-safe, bit 0
// of data) are always ready and should be made while idle.
module base64_stream_encoder (
  input logic    clk,
  input logic    rst,
  b64_in_if.sink bytes,
  b64_out_if.source chars,
  b64_cfg_if.sink   cfg
);
  import b64_pkg::*;

  cfg_t cfg_reg;
  job_t push_job;
  job_t head;
  logic push;
  logic full;
  logic pop;
  logic empty;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.padding_enable   <= 1'b1;
      cfg_reg.wrap_enable      <= 1'b1;
      cfg_reg.crlf_enable      <= 1'b0;
      cfg_reg.alt_alpha_enable <= 1'b0;
    end else if (cfg.valid && cfg.ready && cfg.index[7:2] == 6'd0) begin
      unique case (cfg_idx_t'(cfg.index[1:0]))
        REG_PADDING:   cfg_reg.padding_enable   <= cfg.data[0];
        REG_WRAP:      cfg_reg.wrap_enable      <= cfg.data[0];
        REG_CRLF:      cfg_reg.crlf_enable      <= cfg.data[0];
        REG_ALT_ALPHA: cfg_reg.alt_alpha_enable <= cfg.data[0];
      endcase
    end
  end

  b64_front u_front (
    .clk      (clk),
    .rst      (rst),
    .bytes    (bytes),
    .cfg      (cfg_reg),
    .full     (full),
    .push     (push),
    .push_job (push_job)
  );

  b64_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  b64_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .cfg   (cfg_reg),
    .pop   (pop),
    .chars (chars)
  );

endmodule

[rtl/core/b64_checker.sv]
module b64_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last
);

  // a stalled character stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("output item changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // CR never closes a group; the LF that follows it belongs to the same group
  a_cr: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_char == 8'h0D |-> !out_last)
    else $error("CR closes an item");

  a_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_char >= 8'h41 && out_char <= 8'h5A) ||
                  (out_char >= 8'h61 && out_char <= 8'h7A) ||
                  (out_char >= 8'h30 && out_char <= 8'h39) ||
                  out_char == 8'h2B || out_char == 8'h2F || out_char == 8'h2D ||
                  out_char == 8'h5F || out_char == 8'h3D || out_char == 8'h0D ||
                  out_char == 8'h0A)
    else $error("illegal output character");

endmodule

bind base64_stream_encoder b64_checker u_b64_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (chars.valid),
  .out_ready (chars.ready),
  .out_char  (chars.out_char),
  .out_last  (chars.last_char)
);
